// File: rtl/core/i2cee_pkg.sv
package i2cee_pkg;

  localparam int unsigned ADDR_BITS_DEF = 16;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W = 1;

  typedef enum logic [2:0] {
    OP_MATCH_WR = 3'd0,
    OP_MATCH_RD = 3'd1,
    OP_RX_BYTE  = 3'd2,
    OP_TX_EMPTY = 3'd3,
    OP_TX_END   = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_ADDR_HI   = 3'd1,
    PH_ADDR_LO   = 3'd2,
    PH_RECEIVING = 3'd3,
    PH_SENDING   = 3'd4,
    PH_SEND_DONE = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ACC_NONE  = 2'd0,
    ACC_READ  = 2'd1,
    ACC_WRITE = 2'd2
  } access_kind_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_READ_STORE  = 1'd0,
    CFG_WRITE_STORE = 1'd1
  } cfg_index_t;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] rx_byte;
    logic       stop_seen;
    logic       nack_seen;
    logic       arbitration_lost;
    logic       rx_pending;
    logic       is_bus_condition;
  } evt_item_t;

  typedef struct packed {
    logic [1:0]  access_kind;
    logic [15:0] access_address;
    logic [7:0]  write_byte;
    logic        send_filler;
    logic [2:0]  phase;
    logic [15:0] pointer_now;
  } acc_item_t;

  typedef struct packed {
    logic read_store_present;
    logic write_store_present;
  } cfg_t;

endpackage

// File: rtl/core/i2cee_evt_if.sv
interface i2cee_evt_if import i2cee_pkg::*; ();
  logic      valid;
  logic      ready;
  evt_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/core/i2cee_acc_if.sv
interface i2cee_acc_if import i2cee_pkg::*; ();
  logic      valid;
  logic      ready;
  acc_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/core/i2cee_in_stage.sv
module i2cee_in_stage import i2cee_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  i2cee_evt_if.sink  evt,
  input  logic       adv,
  output logic       stage_valid,
  output evt_item_t  stage_item
);

  assign evt.ready = !stage_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (evt.valid && evt.ready) begin
      stage_valid <= 1'b1;
    end else if (adv) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.valid && evt.ready) begin
      stage_item <= evt.payload;
    end
  end

endmodule

// File: rtl/core/i2cee_core.sv
module i2cee_core import i2cee_pkg::*; #(
  parameter int unsigned ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        stage_valid,
  input  evt_item_t   stage_item,
  output logic        adv,
  i2cee_acc_if.source acc
);

  phase_t                 phase;
  phase_t                 phase_next;
  logic [ADDR_BITS-1:0]   ptr;
  logic [ADDR_BITS-1:0]   ptr_next;
  logic [ADDR_BITS-1:0]   ptr_inc;
  logic [ADDR_BITS+15:0]  hi_wide;
  logic [ADDR_BITS+15:0]  lo_wide;
  logic [ADDR_BITS+15:0]  cur_ext;
  logic [ADDR_BITS+15:0]  next_ext;
  access_kind_t           kind;
  logic [15:0]            addr;
  logic [7:0]             wbyte;
  logic                   filler;
  logic                   step;

  assign adv      = !acc.valid || acc.ready;
  assign step     = stage_valid && adv;
  assign ptr_inc  = ptr + ADDR_BITS'(1);
  assign hi_wide  = {ADDR_BITS'(0), stage_item.rx_byte, 8'h00};
  assign lo_wide  = {(ADDR_BITS + 8)'(0), stage_item.rx_byte};
  assign cur_ext  = {16'h0000, ptr};
  assign next_ext = {16'h0000, ptr_next};

  always_comb begin
    phase_next = phase;
    ptr_next   = ptr;
    case (op_t'(stage_item.op))
      OP_MATCH_WR: begin
        phase_next = PH_ADDR_HI;
      end
      OP_MATCH_RD: begin
        phase_next = PH_SENDING;
        ptr_next   = ptr_inc;
      end
      OP_RX_BYTE: begin
        case (phase)
          PH_ADDR_HI: begin
            ptr_next   = hi_wide[ADDR_BITS-1:0];
            phase_next = PH_ADDR_LO;
          end
          PH_ADDR_LO: begin
            ptr_next   = ptr | lo_wide[ADDR_BITS-1:0];
            phase_next = PH_RECEIVING;
          end
          PH_RECEIVING: begin
            ptr_next = ptr_inc;
            if (stage_item.stop_seen) begin
              phase_next = PH_IDLE;
            end
          end
          default: begin
          end
        endcase
      end
      OP_TX_EMPTY: begin
        ptr_next   = ptr_inc;
        phase_next = PH_SEND_DONE;
      end
      OP_TX_END: begin
        if (!stage_item.is_bus_condition) begin
          phase_next = PH_SENDING;
        end else if (stage_item.nack_seen || stage_item.arbitration_lost ||
                     (stage_item.stop_seen && !stage_item.rx_pending)) begin
          phase_next = PH_IDLE;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    kind   = ACC_NONE;
    addr   = 16'h0000;
    wbyte  = 8'h00;
    filler = 1'b0;
    case (op_t'(stage_item.op))
      OP_MATCH_RD, OP_TX_EMPTY: begin
        addr = cur_ext[15:0];
        if (cfg.read_store_present) begin
          kind = ACC_READ;
        end else begin
          filler = 1'b1;
        end
      end
      OP_RX_BYTE: begin
        if (phase == PH_RECEIVING) begin
          addr = cur_ext[15:0];
          if (cfg.write_store_present) begin
            kind  = ACC_WRITE;
            wbyte = stage_item.rx_byte;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      ptr       <= '0;
      acc.valid <= 1'b0;
    end else begin
      if (adv) begin
        acc.valid <= stage_valid;
      end
      if (step) begin
        phase <= phase_next;
        ptr   <= ptr_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      acc.payload.access_kind    <= kind;
      acc.payload.access_address <= addr;
      acc.payload.write_byte     <= wbyte;
      acc.payload.send_filler    <= filler;
      acc.payload.phase          <= phase_next;
      acc.payload.pointer_now    <= next_ext[15:0];
    end
  end

endmodule

// File: rtl/core/i2c_slave_eeprom_subaddress_fsm_unit.sv
// I2C target transaction layer with two-byte EEPROM sub-addressing. Each event item from the
// byte engine yields exactly one result item: the store access to make (read or write at the
// address pointer), the phase after the event and the pointer after it. One item is taken
// per clock cycle; an item passes first through the input register, where the next phase
// and pointer are worked out, and then through the result register, and stalls only when a
// result is not taken.
// Write configuration only while no item is in flight.
module i2c_slave_eeprom_subaddress_fsm_unit import i2cee_pkg::*; #(
  parameter int unsigned ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  i2cee_evt_if.sink              evt,
  i2cee_acc_if.source            acc
);

  cfg_t      cfg;
  logic      adv;
  logic      stage_valid;
  evt_item_t stage_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.read_store_present  <= 1'b1;
      cfg.write_store_present <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_READ_STORE:  cfg.read_store_present  <= cfg_data[0];
        CFG_WRITE_STORE: cfg.write_store_present <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  i2cee_in_stage u_in_stage (
    .clk         (clk),
    .rst         (rst),
    .evt         (evt),
    .adv         (adv),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  i2cee_core #(
    .ADDR_BITS (ADDR_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .stage_valid (stage_valid),
    .stage_item  (stage_item),
    .adv         (adv),
    .acc         (acc)
  );

endmodule

// File: bench/i2cee_access_checker.sv
module i2cee_access_checker import i2cee_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  i2cee_evt_if                   evt,
  i2cee_acc_if                   acc,
  output int unsigned            waiting,
  output int unsigned            mismatches
);

  phase_t      cur_phase;
  logic [15:0] pointer;
  cfg_t        store_cfg;
  acc_item_t   expected_access[$];

  function automatic acc_item_t read_at_pointer(acc_item_t r);
    r.access_address = pointer;
    if (store_cfg.read_store_present) begin
      r.access_kind = ACC_READ;
    end else begin
      r.send_filler = 1'b1;
    end
    pointer = pointer + 16'd1;
    return r;
  endfunction

  function automatic acc_item_t next_access(evt_item_t e);
    acc_item_t r;
    r = '0;
    case (e.op)
      OP_MATCH_WR: cur_phase = PH_ADDR_HI;
      OP_MATCH_RD: begin
        r = read_at_pointer(r);
        cur_phase = PH_SENDING;
      end
      OP_RX_BYTE: begin
        case (cur_phase)
          PH_ADDR_HI: begin
            pointer = {e.rx_byte, 8'h00};
            cur_phase = PH_ADDR_LO;
          end
          PH_ADDR_LO: begin
            pointer = pointer | {8'h00, e.rx_byte};
            cur_phase = PH_RECEIVING;
          end
          PH_RECEIVING: begin
            r.access_address = pointer;
            if (store_cfg.write_store_present) begin
              r.access_kind = ACC_WRITE;
              r.write_byte = e.rx_byte;
            end
            pointer = pointer + 16'd1;
            if (e.stop_seen) begin
              cur_phase = PH_IDLE;
            end
          end
          default: ;
        endcase
      end
      OP_TX_EMPTY: begin
        r = read_at_pointer(r);
        cur_phase = PH_SEND_DONE;
      end
      OP_TX_END: begin
        if (!e.is_bus_condition) begin
          cur_phase = PH_SENDING;
        end else if (e.nack_seen || e.arbitration_lost || (e.stop_seen && !e.rx_pending)) begin
          cur_phase = PH_IDLE;
        end
      end
      default: ;
    endcase
    r.phase = cur_phase;
    r.pointer_now = pointer;
    return r;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    acc_item_t want;
    acc_item_t got;
    if (rst) begin
      cur_phase = PH_IDLE;
      pointer = '0;
      store_cfg = '1;
      expected_access.delete();
      mismatches = 0;
      waiting <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_READ_STORE:  store_cfg.read_store_present = cfg_data[0];
          CFG_WRITE_STORE: store_cfg.write_store_present = cfg_data[0];
          default: ;
        endcase
      end
      if (evt.valid && evt.ready) begin
        expected_access.push_back(next_access(evt.payload));
      end
      if (acc.valid && acc.ready) begin
        got = acc.payload;
        if (expected_access.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result item: expected none, got %h", $time, got);
        end else begin
          want = expected_access.pop_front();
          check_field("access_kind", want.access_kind, got.access_kind);
          check_field("access_address", want.access_address, got.access_address);
          check_field("write_byte", want.write_byte, got.write_byte);
          check_field("send_filler", want.send_filler, got.send_filler);
          check_field("phase", want.phase, got.phase);
          check_field("pointer_now", want.pointer_now, got.pointer_now);
        end
      end
      waiting <= expected_access.size();
    end
  end

endmodule

// File: bench/i2c_slave_eeprom_subaddress_fsm_unit_test.sv
module i2c_slave_eeprom_subaddress_fsm_unit_test;
  import i2cee_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned LONG_HOLD = 80;
  localparam int unsigned EVT_W = $bits(evt_item_t);

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int unsigned waiting;
  int unsigned mismatches;
  int unsigned cycles;
  int unsigned sent;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_req;

  i2cee_evt_if evt ();
  i2cee_acc_if acc ();

  i2c_slave_eeprom_subaddress_fsm_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .evt       (evt),
    .acc       (acc)
  );

  i2cee_access_checker i_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .evt        (evt),
    .acc        (acc),
    .waiting    (waiting),
    .mismatches (mismatches)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) @(posedge clk);
    $display("i2c_slave_eeprom_subaddress_fsm_unit_test NOT OK");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int unsigned hold_left;
    int unsigned hold_done;
    hold_left = 0;
    hold_done = 0;
    acc.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        acc.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left = hold_left - 1;
        acc.ready <= 1'b0;
      end else if (hold_req != hold_done) begin
        hold_done = hold_req;
        hold_left = LONG_HOLD;
        acc.ready <= 1'b0;
      end else begin
        acc.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  function automatic evt_item_t ev(logic [2:0] op, logic [7:0] rx = 8'h00,
                                   logic stop = 1'b0, logic nack = 1'b0, logic al = 1'b0,
                                   logic pend = 1'b0, logic bus = 1'b0);
    evt_item_t it;
    it.op = op;
    it.rx_byte = rx;
    it.stop_seen = stop;
    it.nack_seen = nack;
    it.arbitration_lost = al;
    it.rx_pending = pend;
    it.is_bus_condition = bus;
    return it;
  endfunction

  function automatic evt_item_t bus_event();
    return ev(OP_TX_END, 8'($urandom), 1'($urandom), $urandom_range(0, 3) == 0,
              $urandom_range(0, 3) == 0, 1'($urandom), 1'b1);
  endfunction

  task automatic put_item(evt_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      evt.valid <= 1'b0;
      @(posedge clk);
    end
    evt.valid <= 1'b1;
    evt.payload <= it;
    @(posedge clk);
    while (!evt.ready) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    evt.valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_config(logic rd_store, logic wr_store);
    cfg_we <= 1'b1;
    cfg_index <= CFG_READ_STORE;
    cfg_data <= rd_store;
    @(posedge clk);
    cfg_index <= CFG_WRITE_STORE;
    cfg_data <= wr_store;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_transaction();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 9) begin
      put_item(ev(OP_MATCH_WR));
      put_item(ev(OP_RX_BYTE, 8'($urandom), 1'($urandom)));
      put_item(ev(OP_RX_BYTE, 8'($urandom)));
      repeat ($urandom_range(0, 6)) begin
        put_item(ev(OP_RX_BYTE, 8'($urandom), $urandom_range(0, 7) == 0));
      end
      if ($urandom_range(0, 1) == 0) begin
        put_item(ev(OP_RX_BYTE, 8'($urandom), 1'b1));
      end else begin
        put_item(bus_event());
      end
    end else if (pick < 16) begin
      put_item(ev(OP_MATCH_RD));
      repeat ($urandom_range(0, 6)) put_item(ev(OP_TX_EMPTY));
      if ($urandom_range(0, 1) == 0) begin
        put_item(ev(OP_TX_END));
        put_item(ev(OP_TX_EMPTY));
      end
      put_item(bus_event());
    end else if (pick < 18) begin
      repeat ($urandom_range(1, 4)) put_item(evt_item_t'(EVT_W'($urandom)));
    end else begin
      // cut short: match, at most one byte, then a bus condition
      put_item(ev($urandom_range(0, 1) ? OP_MATCH_WR : OP_MATCH_RD));
      if ($urandom_range(0, 1) == 0) begin
        put_item(ev(OP_RX_BYTE, 8'($urandom), 1'($urandom)));
      end
      put_item(bus_event());
    end
  endtask

  task automatic run_phase(logic rd_store, logic wr_store, int unsigned sidle,
                           int unsigned rstall, int unsigned n, bit hold, bit pause);
    int unsigned goal;
    set_config(rd_store, wr_store);
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    if (hold) begin
      hold_req++;
    end
    goal = sent + n;
    while (sent + n / 2 < goal) run_transaction();
    if (pause) begin
      drain();
    end
    while (sent < goal) run_transaction();
    drain();
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= CFG_READ_STORE;
    cfg_data <= '0;
    evt.valid <= 1'b0;
    evt.payload <= '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_config(1'b1, 1'b1);
    put_item(ev(OP_RX_BYTE, 8'h3C));
    put_item(ev(OP_MATCH_WR));
    put_item(ev(OP_RX_BYTE, 8'hFF, 1'b1));
    put_item(ev(OP_RX_BYTE, 8'hFF));
    put_item(ev(OP_RX_BYTE, 8'hA5));
    put_item(ev(OP_RX_BYTE, 8'h00, 1'b1));
    put_item(ev(OP_MATCH_RD));
    put_item(ev(OP_RX_BYTE, 8'h11));
    put_item(ev(OP_TX_EMPTY));
    put_item(ev(OP_TX_END));
    put_item(ev(OP_TX_END, 8'h00, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1));
    put_item(ev(OP_TX_END, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    put_item(ev(OP_TX_END, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1));
    put_item(ev(OP_TX_EMPTY));
    put_item(ev(OP_MATCH_RD));
    put_item(ev(OP_TX_END, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1));
    put_item(ev(OP_MATCH_WR));
    put_item(ev(OP_TX_END, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1));
    for (int c = OP_TX_END + 1; c < 8; c++) begin
      put_item(ev(3'(c), 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
    end
    drain();

    set_config(1'b0, 1'b0);
    put_item(ev(OP_MATCH_RD));
    put_item(ev(OP_MATCH_WR));
    put_item(ev(OP_RX_BYTE, 8'h80));
    put_item(ev(OP_RX_BYTE, 8'h01));
    put_item(ev(OP_RX_BYTE, 8'h7E, 1'b1));
    drain();

    run_phase(1'b1, 1'b1, 0, 0, 250, 1'b1, 1'b0);
    run_phase(1'b0, 1'b1, 79, 0, 200, 1'b0, 1'b0);
    run_phase(1'b1, 1'b0, 0, 79, 200, 1'b0, 1'b1);
    run_phase(1'b0, 1'b0, 32, 32, 250, 1'b0, 1'b0);
    run_phase(1'b1, 1'b1, 0, 0, 250, 1'b0, 1'b0);

    if (mismatches == 0) begin
      $display("i2c_slave_eeprom_subaddress_fsm_unit_test OK");
    end else begin
      $display("i2c_slave_eeprom_subaddress_fsm_unit_test NOT OK");
    end
    $finish;
  end

endmodule
